[hdl/cpa_pkg.sv]
package cpa_pkg;

    // Bandwidth codes.
    localparam logic [1:0] BW_125K = 2'd0;
    localparam logic [1:0] BW_250K = 2'd1;
    localparam logic [1:0] BW_500K = 2'd2;
    localparam logic [1:0] BW_NONE = 2'd3;

    // Spreading factors that switch on low-data-rate optimization.
    localparam logic [3:0] SF_LDRO_LO = 4'd11;
    localparam logic [3:0] SF_LDRO_HI = 4'd12;

    // Terms of the payload symbol numerator.
    localparam logic [11:0] LEN_BIAS  = 12'd28;
    localparam logic [11:0] CRC_BITS  = 12'd16;
    localparam logic [11:0] IMPL_BITS = 12'd20;

    // The 4.25 symbol preamble tail in quarter symbols, and the fixed payload symbols.
    localparam logic [18:0] QTR_FIXED = 19'd17;
    localparam logic [13:0] PAY_FIXED = 14'd8;

    // Rounding: ms = floor((Y + 999) / 1000), where Y = Q * 2^(SF+1) / 2^BW.
    localparam logic [35:0] ROUND_UP  = 36'd999;
    localparam logic [35:0] SAT_LIMIT = 36'd4194304000;
    localparam logic [29:0] MS_RECIP  = 30'd549755814;   // ceil(2^36 / 125)
    localparam logic [21:0] AIR_MAX_MS = 22'h3FFFFF;

    typedef struct packed {
        logic [15:0] preamble_symbols;
        logic [3:0]  spreading_factor;
        logic [1:0]  bandwidth_code;
        logic [2:0]  code_rate;
        logic        crc_enabled;
        logic        implicit_header;
        logic [7:0]  payload_bytes;
    } pkt_t;

    // Packet length in quarter symbols and what the scaling stages need.
    typedef struct packed {
        logic [18:0] qtr_symbols;
        logic [3:0]  sf;
        logic [1:0]  bw;
        logic        bad;
    } sym_t;

    typedef struct packed {
        logic [21:0] ms;
        logic        sat;
        logic        bad;
    } res_t;

    // ceil(2^14 / k); exact floor division of values below 1024 by k.
    function automatic logic [14:0] ceil_recip(input logic [3:0] k);
        logic [14:0] r;
        case (k)
            4'd1:    r = 15'd16384;
            4'd2:    r = 15'd8192;
            4'd3:    r = 15'd5462;
            4'd4:    r = 15'd4096;
            4'd5:    r = 15'd3277;
            4'd6:    r = 15'd2731;
            4'd7:    r = 15'd2341;
            4'd8:    r = 15'd2048;
            4'd9:    r = 15'd1821;
            4'd10:   r = 15'd1639;
            4'd11:   r = 15'd1490;
            4'd12:   r = 15'd1366;
            4'd13:   r = 15'd1261;
            4'd14:   r = 15'd1171;
            4'd15:   r = 15'd1093;
            default: r = 15'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/cpa_symbols.sv]
module cpa_symbols (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cpa_pkg::pkt_t in_pkt,
    output logic          out_valid,
    input  logic          out_ready,
    output cpa_pkg::sym_t out_sym
);
    import cpa_pkg::*;

    // Stage 1: numerator, divisor and reciprocal lookup.
    logic        s1_vld_reg, s1_vld_next;
    logic [9:0]  s1_m_reg, s1_m_next;
    logic [14:0] s1_recip_reg, s1_recip_next;
    logic [2:0]  s1_cr_reg;
    logic [15:0] s1_pre_reg;
    logic [3:0]  s1_sf_reg;
    logic [1:0]  s1_bw_reg;
    logic        s1_bad_reg, s1_bad_next;

    // Stage 2: ceiling quotient.
    logic        s2_vld_reg, s2_vld_next;
    logic [9:0]  s2_c_reg, s2_c_next;
    logic [2:0]  s2_cr_reg;
    logic [15:0] s2_pre_reg;
    logic [3:0]  s2_sf_reg;
    logic [1:0]  s2_bw_reg;
    logic        s2_bad_reg;

    // Stage 3: total length in quarter symbols.
    logic        s3_vld_reg, s3_vld_next;
    logic [18:0] s3_q_reg, s3_q_next;
    logic [3:0]  s3_sf_reg;
    logic [1:0]  s3_bw_reg;
    logic        s3_bad_reg;

    logic        rdy1, rdy2, rdy3;
    logic        ldro;
    logic [3:0]  k;
    logic [11:0] pos, neg, a;
    logic [24:0] prod;
    logic [3:0]  cr_fac;
    logic [13:0] pay_sym;

    assign rdy3     = !s3_vld_reg || out_ready;
    assign rdy2     = !s2_vld_reg || rdy3;
    assign rdy1     = !s1_vld_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        ldro = ((in_pkt.bandwidth_code == BW_125K) &&
                ((in_pkt.spreading_factor == SF_LDRO_LO) ||
                 (in_pkt.spreading_factor == SF_LDRO_HI))) ||
               ((in_pkt.bandwidth_code == BW_250K) &&
                (in_pkt.spreading_factor == SF_LDRO_HI));
        k = ldro ? in_pkt.spreading_factor - 4'd2 : in_pkt.spreading_factor;

        pos = 12'({in_pkt.payload_bytes, 3'b000}) + LEN_BIAS +
              (in_pkt.crc_enabled ? CRC_BITS : 12'd0);
        neg = 12'({in_pkt.spreading_factor, 2'b00}) +
              (in_pkt.implicit_header ? IMPL_BITS : 12'd0);
        // ceil(n / 4k) = floor(floor((n + 4k - 1) / 4) / k).
        a = pos + 12'({k, 2'b00}) - 12'd1 - neg;

        // A zero quotient leaves the payload at its fixed eight symbols.
        s1_m_next     = ((pos > neg) && (k != 4'd0)) ? a[11:2] : 10'd0;
        s1_recip_next = ceil_recip(k);
        s1_bad_next   = (in_pkt.bandwidth_code == BW_NONE);
        s1_vld_next   = rdy1 ? in_valid : s1_vld_reg;
    end

    always_comb begin
        prod        = 25'(s1_m_reg) * 25'(s1_recip_reg);
        s2_c_next   = prod[23:14];
        s2_vld_next = rdy2 ? s1_vld_reg : s2_vld_reg;
    end

    always_comb begin
        cr_fac      = 4'(s2_cr_reg) + 4'd4;
        pay_sym     = PAY_FIXED + 14'(s2_c_reg) * 14'(cr_fac);
        s3_q_next   = 19'({s2_pre_reg, 2'b00}) + QTR_FIXED + 19'({pay_sym, 2'b00});
        s3_vld_next = rdy3 ? s2_vld_reg : s3_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_m_reg     <= s1_m_next;
            s1_recip_reg <= s1_recip_next;
            s1_cr_reg    <= in_pkt.code_rate;
            s1_pre_reg   <= in_pkt.preamble_symbols;
            s1_sf_reg    <= in_pkt.spreading_factor;
            s1_bw_reg    <= in_pkt.bandwidth_code;
            s1_bad_reg   <= s1_bad_next;
        end
        if (rdy2) begin
            s2_c_reg   <= s2_c_next;
            s2_cr_reg  <= s1_cr_reg;
            s2_pre_reg <= s1_pre_reg;
            s2_sf_reg  <= s1_sf_reg;
            s2_bw_reg  <= s1_bw_reg;
            s2_bad_reg <= s1_bad_reg;
        end
        if (rdy3) begin
            s3_q_reg   <= s3_q_next;
            s3_sf_reg  <= s2_sf_reg;
            s3_bw_reg  <= s2_bw_reg;
            s3_bad_reg <= s2_bad_reg;
        end
    end

    assign out_valid           = s3_vld_reg;
    assign out_sym.qtr_symbols = s3_q_reg;
    assign out_sym.sf          = s3_sf_reg;
    assign out_sym.bw          = s3_bw_reg;
    assign out_sym.bad         = s3_bad_reg;

endmodule

[hdl/cpa_scale.sv]
module cpa_scale (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cpa_pkg::sym_t in_sym,
    output logic          out_valid,
    input  logic          out_ready,
    output cpa_pkg::res_t out_res
);
    import cpa_pkg::*;

    // Stage A: scale by symbol time and add the rounding term.
    logic        sa_vld_reg, sa_vld_next;
    logic [28:0] sa_z_reg, sa_z_next;
    logic        sa_sat_reg, sa_sat_next;
    logic        sa_bad_reg;

    // Stage B: divide by 1000 through a reciprocal multiply.
    logic        sb_vld_reg, sb_vld_next;
    logic [21:0] sb_ms_reg, sb_ms_next;
    logic        sb_sat_reg;
    logic        sb_bad_reg;

    logic        rdya, rdyb;
    logic [34:0] wide, y;
    logic [35:0] z;
    logic [58:0] prod;

    assign rdyb     = !sb_vld_reg || out_ready;
    assign rdya     = !sa_vld_reg || rdyb;
    assign in_ready = rdya;

    always_comb begin
        wide = 35'(in_sym.qtr_symbols) << (5'(in_sym.sf) + 5'd1);
        y    = wide >> in_sym.bw;
        z    = 36'(y) + ROUND_UP;
        // Below the limit z fits 32 bits, and z / 1000 = (z / 8) / 125.
        sa_sat_next = (z >= SAT_LIMIT);
        sa_z_next   = z[31:3];
        sa_vld_next = rdya ? in_valid : sa_vld_reg;
    end

    always_comb begin
        prod        = 59'(sa_z_reg) * 59'(MS_RECIP);
        sb_ms_next  = prod[57:36];
        sb_vld_next = rdyb ? sa_vld_reg : sb_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_vld_reg <= 1'b0;
            sb_vld_reg <= 1'b0;
        end else begin
            sa_vld_reg <= sa_vld_next;
            sb_vld_reg <= sb_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdya) begin
            sa_z_reg   <= sa_z_next;
            sa_sat_reg <= sa_sat_next;
            sa_bad_reg <= in_sym.bad;
        end
        if (rdyb) begin
            sb_ms_reg  <= sb_ms_next;
            sb_sat_reg <= sa_sat_reg;
            sb_bad_reg <= sa_bad_reg;
        end
    end

    assign out_valid   = sb_vld_reg;
    assign out_res.ms  = sb_ms_reg;
    assign out_res.sat = sb_sat_reg;
    assign out_res.bad = sb_bad_reg;

endmodule

[hdl/chirp_packet_airtime_unit.sv]
// Time on air of one chirp-spread-spectrum packet in milliseconds, computed
// exactly in quarter-symbol units and rounded as floor(t + 0.999), saturating
// at 4194303 ms. Each packet description yields one result. The pipeline has
// six register stages; one request is accepted every cycle while the output
// side is ready, and per-stage valid bits let earlier stages keep filling
// while the output register is stalled. Bandwidth code 3 returns bad_bandwidth
// with a time of 0.
module chirp_packet_airtime_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] preamble_symbols, [19:16] spreading_factor, [21:20] bandwidth_code,
    // [24:22] code_rate, [25] crc_enabled, [26] implicit_header,
    // [34:27] payload_bytes, [39:35] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [21:0] airtime_ms, [22] bad_bandwidth, [23] zero
    output logic [23:0] m_axis_tdata
);
    import cpa_pkg::*;

    pkt_t        pkt;
    sym_t        sym;
    res_t        res;
    logic        sym_valid, sym_ready;
    logic        res_valid, res_ready;

    logic        out_vld_reg, out_vld_next;
    logic [21:0] out_ms_reg, out_ms_next;
    logic        out_bad_reg;

    assign pkt.preamble_symbols = s_axis_tdata[15:0];
    assign pkt.spreading_factor = s_axis_tdata[19:16];
    assign pkt.bandwidth_code   = s_axis_tdata[21:20];
    assign pkt.code_rate        = s_axis_tdata[24:22];
    assign pkt.crc_enabled      = s_axis_tdata[25];
    assign pkt.implicit_header  = s_axis_tdata[26];
    assign pkt.payload_bytes    = s_axis_tdata[34:27];

    cpa_symbols u_symbols (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pkt    (pkt),
        .out_valid (sym_valid),
        .out_ready (sym_ready),
        .out_sym   (sym)
    );

    cpa_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sym_valid),
        .in_ready  (sym_ready),
        .in_sym    (sym),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_res   (res)
    );

    assign res_ready = !out_vld_reg || m_axis_tready;

    always_comb begin
        if (res.bad) begin
            out_ms_next = 22'd0;
        end else if (res.sat) begin
            out_ms_next = AIR_MAX_MS;
        end else begin
            out_ms_next = res.ms;
        end
        out_vld_next = res_ready ? res_valid : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready) begin
            out_ms_reg  <= out_ms_next;
            out_bad_reg <= res.bad;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_bad_reg, out_ms_reg};

endmodule
